[rtl/core/six_axis_tare_offset_unit_defines.svh]
// ----------------------------------------------------------------------------
// six-axis tare offset unit: assertion macros
// shared concurrent checks, clocked on clk and held off during rst
// ----------------------------------------------------------------------------
`ifndef SIX_AXIS_TARE_OFFSET_UNIT_DEFINES_SVH
`define SIX_AXIS_TARE_OFFSET_UNIT_DEFINES_SVH

// same-cycle implication
`define TARE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TARE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/sixtare_pkg.sv]
// ----------------------------------------------------------------------------
// sixtare_pkg
// types, codes and helpers shared by the six-axis tare offset unit
// ----------------------------------------------------------------------------
package sixtare_pkg;

  localparam int NUM_AXES = 6;
  localparam int OUT_W    = 32;
  localparam int SEL_W    = 3;
  localparam int CNT_W    = 7;

  // quotient bits retired per divider step
  localparam int DIV_DIG_W = 8;

  // input opcodes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_ZERO   = 1'b1;

  // result kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_ACK    = 1'b1;

  // axis selector code for all six axes
  localparam logic [SEL_W-1:0] AXIS_ALL = 3'd0;

  typedef logic [NUM_AXES-1:0][OUT_W-1:0] axis_vec_t;

  typedef struct packed {
    logic      kind;
    axis_vec_t val;
  } result_t;

  // per-lane control from the sequencer
  typedef struct packed {
    logic clear;   // zero the accumulator
    logic accum;   // add the sample into the accumulator
    logic load;    // load divider from the accumulator
    logic step;    // one divider iteration
    logic commit;  // write the quotient into the offset
  } lane_ctl_t;

  function automatic logic axis_hit(logic [SEL_W-1:0] sel, int unsigned lane);
    return (sel == AXIS_ALL) || (sel == SEL_W'(lane + 1));
  endfunction

endpackage

[rtl/core/sixtare_lane.sv]
// ----------------------------------------------------------------------------
// sixtare_lane
// one axis: tare accumulator, digit-serial rounding divider, offset, correction
// ----------------------------------------------------------------------------
module sixtare_lane import sixtare_pkg::*; #(
  parameter int ZERO_SAMPLES = 100,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  lane_ctl_t        ctl,
  input  logic [OUT_W-1:0] sample,
  output logic [OUT_W-1:0] corrected
);

  localparam int EFF_W  = (SAMPLE_WIDTH > OUT_W) ? OUT_W : SAMPLE_WIDTH;
  localparam int SUM_W  = EFF_W + $clog2(ZERO_SAMPLES + 1);
  localparam int REM_W  = $clog2(ZERO_SAMPLES + 1);
  localparam int DW     = EFF_W + 1;
  localparam int NDIG   = (SUM_W + DIV_DIG_W - 1) / DIV_DIG_W;
  localparam int PAD_W  = NDIG * DIV_DIG_W;
  localparam int PW     = REM_W + DIV_DIG_W;
  localparam int RCP_SH = DIV_DIG_W + 2 * REM_W;
  localparam int PRD_W  = PW + RCP_SH + 1;
  localparam longint RECIP_L =
    ((longint'(1) << RCP_SH) + ZERO_SAMPLES - 1) / ZERO_SAMPLES;
  localparam logic [SUM_W-1:0] HALF  = SUM_W'(ZERO_SAMPLES / 2);
  localparam logic [PW-1:0]    DIV_K = PW'(ZERO_SAMPLES);
  localparam logic [PRD_W-1:0] RECIP = PRD_W'(RECIP_L);

  logic signed [EFF_W-1:0] samp;
  logic signed [SUM_W-1:0] sum;
  logic signed [EFF_W-1:0] offset;
  logic [SUM_W-1:0]        mag;
  logic [PAD_W-1:0]        quot;
  logic [REM_W-1:0]        rem;
  logic                    neg;
  logic [PW-1:0]           part;
  logic [PRD_W-1:0]        prod;
  logic [DIV_DIG_W-1:0]    qd;
  logic [PW-1:0]           back;
  logic [PW-1:0]           rd;
  logic [EFF_W-1:0]        qlow;
  logic signed [DW-1:0]    diff;

  assign samp = sample[EFF_W-1:0];

  // magnitude plus half divisor gives round half away from zero
  assign mag = (sum[SUM_W-1] ? $unsigned(-sum) : $unsigned(sum)) + HALF;

  // one quotient digit: remainder and next dividend digit, divided by a
  // reciprocal multiply that is exact over the partial dividend range
  assign part = {rem, quot[PAD_W-1 -: DIV_DIG_W]};
  assign prod = PRD_W'(part) * RECIP;
  assign qd   = prod[RCP_SH +: DIV_DIG_W];
  assign back = PW'(qd) * DIV_K;
  assign rd   = part - back;
  assign qlow = quot[EFF_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sum    <= '0;
      offset <= '0;
    end else begin
      if (ctl.clear) begin
        sum <= '0;
      end else if (ctl.accum) begin
        sum <= sum + SUM_W'(samp);
      end
      if (ctl.commit) begin
        offset <= neg ? -qlow : qlow;
      end
    end
  end

  // long division, one quotient digit per step
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      neg  <= sum[SUM_W-1];
      quot <= PAD_W'(mag);
      rem  <= '0;
    end else if (ctl.step) begin
      quot <= {quot[PAD_W-DIV_DIG_W-1:0], qd};
      rem  <= rd[REM_W-1:0];
    end
  end

  assign diff = DW'(samp) - DW'(offset);

  generate
    if (SAMPLE_WIDTH > EFF_W) begin : g_wide
      assign corrected = diff[OUT_W-1:0];
    end else begin : g_sat
      logic signed [EFF_W-1:0] sat;
      always_comb begin
        if (diff[DW-1] != diff[DW-2]) begin
          sat = diff[DW-1] ? {1'b1, {(EFF_W-1){1'b0}}} : {1'b0, {(EFF_W-1){1'b1}}};
        end else begin
          sat = diff[EFF_W-1:0];
        end
      end
      assign corrected = OUT_W'(sat);
    end
  endgenerate

endmodule

[rtl/core/sixtare_outq.sv]
// ----------------------------------------------------------------------------
// sixtare_outq
// merges lane results into one output word, two-entry output queue
// ----------------------------------------------------------------------------
module sixtare_outq import sixtare_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  logic      kind,
  input  axis_vec_t lane_val,
  output logic      full,
  output logic      out_valid,
  input  logic      out_ready,
  output result_t   head
);

  result_t    entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;
  result_t    word;

  // an acknowledge carries zero payload
  always_comb begin
    word.kind = kind;
    word.val  = (kind == KIND_ACK) ? '0 : lane_val;
  end

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign head      = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

[rtl/core/six_axis_tare_offset_unit.sv]
// ----------------------------------------------------------------------------
// six_axis_tare_offset_unit
// six-axis force/torque tare: averages a window of samples per axis into
// offsets and subtracts them (saturating unless SAMPLE_WIDTH > OUT_W) from the sample stream
// ----------------------------------------------------------------------------
//
//  channel  handshake             payload
//  -------  --------------------  -------------------------------------------
//  in       in_valid / in_ready   opcode, axis_select, force_*, torque_*
//  out      out_valid / out_ready result_kind, out_force_*, out_torque_*
//
//  one word per cycle while not dividing and the queue has room; a result enters the output queue at the accept edge
//  the sample that closes a tare starts six per-lane dividers, one 8-bit
//  quotient digit per cycle: input stalls while the dividers run and the offsets commit
//  rst is synchronous; clears offsets, sums, tare state and the queue
//  a two-entry output queue keeps input flowing, until full, while out_ready is low
//
`include "six_axis_tare_offset_unit_defines.svh"

module six_axis_tare_offset_unit import sixtare_pkg::*; #(
  parameter int ZERO_SAMPLES = 100,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             opcode,
  input  logic [SEL_W-1:0] axis_select,
  input  logic [OUT_W-1:0] force_x,
  input  logic [OUT_W-1:0] force_y,
  input  logic [OUT_W-1:0] force_z,
  input  logic [OUT_W-1:0] torque_x,
  input  logic [OUT_W-1:0] torque_y,
  input  logic [OUT_W-1:0] torque_z,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             result_kind,
  output logic [OUT_W-1:0] out_force_x,
  output logic [OUT_W-1:0] out_force_y,
  output logic [OUT_W-1:0] out_force_z,
  output logic [OUT_W-1:0] out_torque_x,
  output logic [OUT_W-1:0] out_torque_y,
  output logic [OUT_W-1:0] out_torque_z
);

  localparam int EFF_W  = (SAMPLE_WIDTH > OUT_W) ? OUT_W : SAMPLE_WIDTH;
  localparam int SUM_W  = EFF_W + $clog2(ZERO_SAMPLES + 1);
  localparam int NDIG   = (SUM_W + DIV_DIG_W - 1) / DIV_DIG_W;
  localparam int DCNT_W = $clog2(NDIG + 1);
  localparam logic [CNT_W-1:0]  ZS_CNT   = CNT_W'(ZERO_SAMPLES);
  localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(NDIG);

  // sequencer states
  localparam logic ST_RUN = 1'b0;
  localparam logic ST_DIV = 1'b1;

  logic              state;
  logic              tare_active;
  logic [CNT_W-1:0]  tare_count;
  logic [SEL_W-1:0]  tare_axis;
  logic [DCNT_W-1:0] div_cnt;

  logic       fire;
  logic       is_zero;
  logic       tare_done;
  logic       tare_close;
  logic       push;
  logic       q_full;
  axis_vec_t  sample_vec;
  axis_vec_t  corr_vec;
  lane_ctl_t  ctl [NUM_AXES];
  result_t    head;

  assign in_ready = (state == ST_RUN) && !q_full;
  assign fire     = in_valid && in_ready;
  assign is_zero  = (opcode == OP_ZERO);

  // window full: this sample is swallowed and the divide starts
  assign tare_done  = !(tare_count < ZS_CNT);
  assign tare_close = fire && !is_zero && tare_active && tare_done;

  // zero requests acknowledge at once; samples outside a tare pass through
  assign push = fire && (is_zero || !tare_active);

  assign sample_vec = {torque_z, torque_y, torque_x, force_z, force_y, force_x};

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      ctl[i].clear  = fire && is_zero && axis_hit(axis_select, i);
      ctl[i].accum  = fire && !is_zero && tare_active && !tare_done
                      && axis_hit(tare_axis, i);
      ctl[i].load   = tare_close;
      ctl[i].step   = (state == ST_DIV) && (div_cnt < DIV_LAST);
      ctl[i].commit = (state == ST_DIV) && (div_cnt == DIV_LAST)
                      && axis_hit(tare_axis, i);
    end
  end

  // tare sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_RUN;
      tare_active <= 1'b0;
      tare_count  <= '0;
      tare_axis   <= AXIS_ALL;
      div_cnt     <= '0;
    end else begin
      case (state)
        ST_RUN: begin
          if (fire && is_zero) begin
            // a new request abandons any running tare
            tare_axis   <= axis_select;
            tare_active <= 1'b1;
            tare_count  <= '0;
          end else if (tare_close) begin
            tare_active <= 1'b0;
            tare_count  <= '0;
            div_cnt     <= '0;
            state       <= ST_DIV;
          end else if (fire && tare_active) begin
            tare_count <= tare_count + CNT_W'(1);
          end
        end
        ST_DIV: begin
          if (div_cnt == DIV_LAST) begin
            state <= ST_RUN;
          end else begin
            div_cnt <= div_cnt + DCNT_W'(1);
          end
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

  // one lane per axis
  generate
    for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
      sixtare_lane #(
        .ZERO_SAMPLES (ZERO_SAMPLES),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
      ) u_lane (
        .clk       (clk),
        .rst       (rst),
        .ctl       (ctl[g]),
        .sample    (sample_vec[g]),
        .corrected (corr_vec[g])
      );
    end
  endgenerate

  // merge lanes into the output word
  sixtare_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .kind      (is_zero ? KIND_ACK : KIND_SAMPLE),
    .lane_val  (corr_vec),
    .full      (q_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign result_kind  = head.kind;
  assign out_force_x  = head.val[0];
  assign out_force_y  = head.val[1];
  assign out_force_z  = head.val[2];
  assign out_torque_x = head.val[3];
  assign out_torque_y = head.val[4];
  assign out_torque_z = head.val[5];

  // checks
  `TARE_ASSERT_NOW(a_div_blocks_input, state == ST_DIV, !in_ready,
    "input accepted while dividers run")
  `TARE_ASSERT_NOW(a_div_no_tare, state == ST_DIV, !tare_active && tare_count == '0,
    "tare still active during divide")
  `TARE_ASSERT_NEXT(a_close_starts_div, tare_close, state == ST_DIV && div_cnt == '0,
    "divide did not start after closing sample")
  `TARE_ASSERT_NOW(a_count_bound, tare_active, tare_count <= ZS_CNT,
    "tare count beyond window")

endmodule
